// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
// ---------------------------------------------------------------------------
// bba_pkg
// Types, constants and helpers shared by the buddy block allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package bba_pkg;
   localparam int TOP_ORDER = 8;
   localparam int MIN_SHIFT = 4;
   localparam int MIN_BLOCK = 16;
   localparam int MASK_W    = TOP_ORDER + 1;
   localparam int ORDER_W   = 4;
   localparam int NODE_W    = TOP_ORDER + 1;
   localparam int ROW_AW    = TOP_ORDER;
   localparam int ROWS      = 1 << ROW_AW;
   localparam int OFF_W     = 12;
   localparam int SIZE_W    = 13;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 24;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_BADOFF = 2'd2;

   typedef enum logic [1:0] {
      NS_UNUSED = 2'd0,
      NS_FREE   = 2'd1,
      NS_SPLIT  = 2'd2,
      NS_USED   = 2'd3
   } nstat_type;

   // mask: orders of free blocks anywhere in this subtree
   typedef struct packed {
      nstat_type           status;
      logic [MASK_W-1:0]   mask;
   } entry_type;

   typedef struct packed {
      entry_type right;
      entry_type left;
   } row_type;

   // status in the low bits
   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [OFF_W-1:0]   offset;
      logic [1:0]         status;
   } result_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic pick;
      logic found;
      logic asc_rd;
      logic asc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic need_desc;
      logic asc_needed;
      logic parent_root;
   } stat_type;

   function automatic logic [MASK_W-1:0] order_bit(input logic [ORDER_W-1:0] o);
      order_bit = MASK_W'(1) << o;
   endfunction

   function automatic logic [OFF_W-1:0] offset_of(input logic [NODE_W-1:0] node,
                                                 input logic [ORDER_W-1:0] o);
      logic [NODE_W+OFF_W-1:0] tmp;
      tmp = (NODE_W+OFF_W)'(node) << (o + ORDER_W'(MIN_SHIFT));
      offset_of = tmp[OFF_W-1:0];
   endfunction
endpackage

// ===== rtl/bba_ctrl.sv =====
// ---------------------------------------------------------------------------
// bba_ctrl
// Sequencer for clear, tree descent, ascent and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_ctrl import bba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type st,
   output cmd_type  cmd
);
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DESC  = 7'b0000100,
      S_PICK  = 7'b0001000,
      S_FOUND = 7'b0010000,
      S_AREAD = 7'b0100000,
      S_AWR   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE) && !done_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      done_in      = done_ff;
      cmd.out_load = done_ff && (!rsp_valid_ff || rsp_tready);
      if (cmd.out_load) begin
         done_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_DESC;
            end
         end
         S_DESC: begin
            state_in = st.need_desc ? S_PICK : S_FOUND;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_DESC;
         end
         S_FOUND: begin
            cmd.found = 1'b1;
            if (st.asc_needed) begin
               state_in = S_AREAD;
            end else begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         S_AREAD: begin
            cmd.asc_rd = 1'b1;
            state_in   = S_AWR;
         end
         S_AWR: begin
            cmd.asc = 1'b1;
            if (st.parent_root) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = S_AREAD;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_PROP(a_rsp_rise, clock, reset, $rose(rsp_tvalid) |-> $past(done_ff), "result without finished op")
   `ASSERT_NEVER(a_no_acc_clear, clock, reset, (state_ff == S_CLEAR) && req_tready, "accept during clear")
endmodule

// ===== rtl/bba_datapath.sv =====
// ---------------------------------------------------------------------------
// bba_datapath
// Node tree store, root entry, walk registers and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_datapath import bba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         st,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tuser,
   output logic [RSP_W-1:0] rsp_tdata
);
   row_type mem [ROWS];
   row_type rd_row_ff;

   logic [ROW_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   entry_type          root_ff;
   logic               op_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [ORDER_W-1:0] k_ff, j_ff, order_ff;
   logic               nofit_ff, merge_ff;
   logic [NODE_W-1:0]  node_ff;
   entry_type          ent_ff;
   result_type         res_ff;
   logic [RSP_W-1:0]   out_ff;

   logic [SIZE_W-1:0]  size_in;
   logic [SIZE_W-1:0]  size1;
   logic [ORDER_W-1:0] k_calc, j_calc;
   logic               big, none;
   logic [ROW_AW-1:0]  rd_addr, wr_addr;
   logic               wr_en;
   row_type            wr_row, asc_row;
   logic               child_right;
   logic [ORDER_W-1:0] bit_idx;
   logic [NODE_W-1:0]  t_node;
   logic               free_ok;
   logic               alloc_hit;
   entry_type          sib, asc_ent;
   logic               merge_now;

   assign size_in = req_tdata[SIZE_W-1:0];
   assign size1   = (size_in == '0) ? SIZE_W'(1) : size_in;

   always_comb begin
      k_calc = '0;
      big    = 1'b1;
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if (((SIZE_W+1)'(MIN_BLOCK) << i) >= (SIZE_W+1)'(size1)) begin
            k_calc = ORDER_W'(i);
            big    = 1'b0;
         end
      end
      j_calc = '0;
      none   = 1'b1;
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if ((ORDER_W'(i) >= k_calc) && root_ff.mask[i]) begin
            j_calc = ORDER_W'(i);
            none   = 1'b0;
         end
      end
   end

   assign bit_idx     = order_ff + ORDER_W'(MIN_SHIFT - 1);
   assign child_right = (op_ff == MODE_ALLOC) ? !rd_row_ff.left.mask[j_ff] : off_ff[bit_idx];
   assign t_node      = node_ff << (j_ff - k_ff);
   assign free_ok     = (ent_ff.status == NS_USED) && (offset_of(node_ff, order_ff) == off_ff);
   assign alloc_hit   = cmd.found && (op_ff == MODE_ALLOC) && !nofit_ff;

   always_comb begin
      sib = node_ff[0] ? rd_row_ff.left : rd_row_ff.right;
      if ((op_ff == MODE_ALLOC) && (order_ff < j_ff)) begin
         sib = '{status: NS_FREE, mask: order_bit(order_ff)};
      end
      merge_now = (op_ff == MODE_FREE) && merge_ff && (sib.status == NS_FREE);
      if (merge_now) begin
         asc_row = '0;
         asc_ent = '{status: NS_FREE, mask: order_bit(order_ff + ORDER_W'(1))};
      end else begin
         asc_row = node_ff[0] ? row_type'{right: ent_ff, left: sib}
                              : row_type'{right: sib, left: ent_ff};
         asc_ent = '{status: NS_SPLIT, mask: ent_ff.mask | sib.mask};
      end
   end

   assign rd_addr = cmd.asc_rd ? node_ff[NODE_W-1:1] : node_ff[ROW_AW-1:0];
   assign wr_en   = cmd.clr || cmd.asc;
   assign wr_addr = cmd.clr ? clr_cnt_ff : node_ff[NODE_W-1:1];
   assign wr_row  = cmd.clr ? '0 : asc_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   assign clr_cnt_in     = cmd.clr ? clr_cnt_ff + ROW_AW'(1) : clr_cnt_ff;
   assign st.clr_last    = (clr_cnt_ff == ROW_AW'(ROWS - 1));
   assign st.need_desc   = (op_ff == MODE_ALLOC) ? (!nofit_ff && (order_ff != j_ff))
                         : ((ent_ff.status == NS_SPLIT) && (order_ff != '0));
   assign st.asc_needed  = (op_ff == MODE_ALLOC) ? (!nofit_ff && (t_node != NODE_W'(1)))
                         : (free_ok && (node_ff != NODE_W'(1)));
   assign st.parent_root = (node_ff[NODE_W-1:1] == ROW_AW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         root_ff    <= '{status: NS_FREE, mask: order_bit(ORDER_W'(TOP_ORDER))};
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         if (alloc_hit && (t_node == NODE_W'(1))) begin
            root_ff <= '{status: NS_USED, mask: '0};
         end else if (cmd.found && (op_ff == MODE_FREE) && free_ok
                      && (node_ff == NODE_W'(1))) begin
            root_ff <= '{status: NS_FREE, mask: order_bit(order_ff)};
         end else if (cmd.asc && st.parent_root) begin
            root_ff <= asc_ent;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser;
         off_ff   <= req_tdata[SIZE_W+OFF_W-1:SIZE_W];
         k_ff     <= k_calc;
         j_ff     <= j_calc;
         nofit_ff <= (req_tuser == MODE_ALLOC) && (big || none);
         node_ff  <= NODE_W'(1);
         order_ff <= ORDER_W'(TOP_ORDER);
         ent_ff   <= root_ff;
         merge_ff <= 1'b0;
      end else if (cmd.pick) begin
         node_ff  <= {node_ff[NODE_W-2:0], child_right};
         order_ff <= order_ff - ORDER_W'(1);
         ent_ff   <= child_right ? rd_row_ff.right : rd_row_ff.left;
      end else if (cmd.found) begin
         if (op_ff == MODE_ALLOC) begin
            if (nofit_ff) begin
               res_ff <= '{status: ST_NOFIT, offset: '0, order: '0};
            end else begin
               node_ff  <= t_node;
               order_ff <= k_ff;
               ent_ff   <= '{status: NS_USED, mask: '0};
               res_ff   <= '{status: ST_OK, offset: offset_of(t_node, k_ff), order: k_ff};
            end
         end else begin
            if (free_ok) begin
               ent_ff   <= '{status: NS_FREE, mask: order_bit(order_ff)};
               merge_ff <= 1'b1;
               res_ff   <= '{status: ST_OK, offset: off_ff, order: order_ff};
            end else begin
               res_ff <= '{status: ST_BADOFF, offset: '0, order: '0};
            end
         end
      end else if (cmd.asc) begin
         node_ff  <= node_ff >> 1;
         order_ff <= order_ff + ORDER_W'(1);
         ent_ff   <= asc_ent;
         merge_ff <= merge_now;
      end
      if (cmd.out_load) begin
         out_ff <= RSP_W'(res_ff);
      end
   end

   assign rsp_tdata = out_ff;

   `ASSERT_NEVER(a_clr_asc, clock, reset, cmd.clr && (cmd.asc || cmd.load), "walk during clear")
   `ASSERT_PROP(a_wr_row, clock, reset, cmd.asc |-> (node_ff[NODE_W-1:1] != '0), "row zero write")
   `ASSERT_PROP(a_found_ord, clock, reset, alloc_hit |-> (order_ff == j_ff), "bad stop order")
endmodule

// ===== rtl/buddy_block_allocator.sv =====
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 4 KiB region with 16-byte minimum blocks.
// ---------------------------------------------------------------------------
// Channel  Direction  Contents
// req_     in         tuser: mode; tdata: request_size, free_offset
// rsp_     out        tdata: status, block_offset, block_order
//
// After reset a clearing pass writes all 256 rows of the node store;
// req_tready stays low during it.
// An operation walks down the tree with a descent and a pick step per level,
// then walks back up with one store read and one write per row; the next
// transfer is accepted only after the walk is finished.
// A finished result waits in the output register while the next transfer
// is accepted; a stalled rsp_ side stops the block only at its next result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module buddy_block_allocator import bba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // request_size[12:0], free_offset[24:13]
   input  logic             req_tuser,   // mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status[1:0], block_offset[13:2], block_order[17:14]
);
   cmd_type  cmd;
   stat_type st;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );
endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stream-level test of the buddy block allocator: directed and random
// allocate/free transfers, checked against an in-bench buddy tree model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
   import bba_pkg::*;

   localparam int TOP   = TOP_ORDER;
   localparam int SLOTS = 2 << TOP;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic        mode;
      logic [12:0] size;
      logic [11:0] offset;
   } op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   buddy_block_allocator dut (.*);

   always #6 clock = ~clock;

   nstat_type  tree [SLOTS];
   op_type     pending_ops [$];
   result_type expected_results [$];
   logic [11:0] live_blocks [$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0, gap_left = 0;
   int hold_left = 0;
   bit long_hold = 0;

   function automatic logic [11:0] node_base(int n, int d);
      return 12'((n - (1 << d)) * (MIN_BLOCK << (TOP - d)));
   endfunction

   function automatic result_type predict_alloc(int unsigned sz);
      result_type r;
      int k, j, n, found, d;
      r = '0;
      r.status = ST_NOFIT;
      k = 0;
      found = 0;
      if (sz == 0) sz = 1;
      while (k <= TOP && (MIN_BLOCK << k) < sz) k++;
      if (k > TOP) return r;
      for (j = k; j <= TOP && found == 0; j++)
         for (n = 1 << (TOP - j); n < (2 << (TOP - j)); n++)
            if (found == 0 && tree[n] == NS_FREE) found = n;
      if (found == 0) return r;
      n = found;
      d = TOP - (j - 1);
      while (TOP - d > k) begin
         tree[n] = NS_SPLIT;
         tree[2*n] = NS_FREE;
         tree[2*n+1] = NS_FREE;
         n = 2 * n;
         d++;
      end
      tree[n] = NS_USED;
      r.status = ST_OK;
      r.offset = node_base(n, d);
      r.order = 4'(k);
      return r;
   endfunction

   function automatic result_type predict_free(logic [11:0] off);
      result_type r;
      int n, d;
      r = '0;
      r.status = ST_BADOFF;
      n = 1;
      d = 0;
      while (tree[n] == NS_SPLIT && d < TOP) begin
         d++;
         n = (1 << d) + ((off / MIN_BLOCK) >> (TOP - d));
      end
      if (tree[n] != NS_USED || node_base(n, d) != off) return r;
      r.status = ST_OK;
      r.offset = off;
      r.order = 4'(TOP - d);
      tree[n] = NS_FREE;
      while (n > 1 && tree[n ^ 1] == NS_FREE) begin
         tree[n] = NS_UNUSED;
         tree[n ^ 1] = NS_UNUSED;
         n = n >> 1;
         tree[n] = NS_FREE;
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("tb_top: mismatch %s got %0d want %0d", what, got, want);
      errors++;
   endtask

   task automatic add_op(op_type o);
      pending_ops = {pending_ops, o};
   endtask

   function automatic op_type alloc_op(int unsigned sz);
      op_type o;
      o = '0;
      o.mode = MODE_ALLOC;
      o.size = 13'(sz);
      o.offset = 12'($urandom);
      return o;
   endfunction

   function automatic op_type free_op(logic [11:0] off);
      op_type o;
      o = '0;
      o.mode = MODE_FREE;
      o.offset = off;
      o.size = 13'($urandom);
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         op_type o;
         result_type r;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            o = pending_ops.pop_front();
            r = (o.mode == MODE_ALLOC) ? predict_alloc(o.size) : predict_free(o.offset);
            expected_results = {expected_results, r};
            if (o.mode == MODE_ALLOC && r.status == ST_OK)
               live_blocks = {live_blocks, r.offset};
            req_tvalid <= 1'b1;
            req_tuser <= o.mode;
            req_tdata <= {7'd0, o.offset, o.size};
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
         end
      end
   end

   // receiver stall pattern and monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_type got, want;
            got = result_type'(rsp_tdata[17:0]);
            if (expected_results.size() == 0) begin
               report("unexpected transfer", 32'(rsp_tdata), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report("status", 32'(got.status), 32'(want.status));
               if (got.offset != want.offset)
                  report("offset", 32'(got.offset), 32'(want.offset));
               if (got.order != want.order)
                  report("order", 32'(got.order), 32'(want.order));
            end
         end
         if (long_hold) begin
            long_hold = 0;
            hold_left = 800;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 7) < 5);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      int i, pick, sz;
      logic [11:0] off;
      for (i = 0; i < SLOTS; i++) tree[i] = NS_UNUSED;
      tree[1] = NS_FREE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: zero size, full region, too large, bad frees, merges
      add_op(alloc_op(0));
      add_op(alloc_op(8191));
      add_op(alloc_op(4097));
      add_op(alloc_op(17));
      add_op(alloc_op(16));
      add_op(free_op(12'd4095));
      add_op(free_op(12'd8));
      add_op(free_op(12'd16));
      add_op(free_op(12'd32));
      add_op(free_op(12'd32));
      add_op(free_op(12'd0));
      add_op(alloc_op(4096));
      add_op(alloc_op(1));
      add_op(free_op(12'd0));
      add_op(free_op(12'd0));
      add_op(alloc_op(2048));
      add_op(alloc_op(2048));
      add_op(alloc_op(2048));
      add_op(free_op(12'd2048));
      add_op(free_op(12'd0));
      wait (pending_ops.size() == 0);

      long_hold = 1;
      for (i = 0; i < 60; i++) add_op(alloc_op($urandom_range(0, 200)));
      wait (pending_ops.size() == 0);

      for (i = 0; i < 780; i++) begin
         while (pending_ops.size() > 2) @(posedge clock);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                  : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4096)
                  : $urandom_range(0, 300));
               add_op(alloc_op(sz));
            end
            4, 5, 6, 7, 8: begin
               if (live_blocks.size() > 0) begin
                  pick = $urandom_range(0, live_blocks.size() - 1);
                  off = live_blocks[pick];
                  live_blocks.delete(pick);
                  add_op(free_op(off));
               end else add_op(alloc_op($urandom_range(0, 64)));
            end
            default: add_op(free_op(12'($urandom)));
         endcase
      end
      wait (pending_ops.size() == 0 && expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule
